// ===== rtl/epd_pkg.sv =====
// Shared types and constants for the encoder position PID drive.
// Used by the top level, core, multiplier and divider; depends on nothing.
package epd_pkg;

	localparam int POS_W    = 16;
	localparam int GAIN_W   = 24;
	localparam int TIME_W   = 24;
	localparam int ERR_W    = 17;
	localparam int DIFF_W   = 18;
	localparam int ACC_W    = 64;
	localparam int PROD_W   = 88;
	localparam int SUM_W    = 66;
	localparam int LEVEL_W  = 8;
	localparam int ITER_W   = 7;
	localparam int MUL_STEPS = 24;

	localparam logic [ITER_W-1:0] DIV_D_ITERS = 7'd64;
	localparam logic [ITER_W-1:0] DIV_I_ITERS = 7'd88;
	localparam logic [TIME_W-1:0] US_PER_S    = 24'd1000000;
	localparam logic [49:0]       PWM_MAX     = 50'd255;
	localparam logic [49:0]       LEVEL_MAX   = (PWM_MAX > 50'd255) ? 50'd255 : PWM_MAX;
	localparam logic [PROD_W-1:0] I_LIMIT     = {25'd0, 1'b1, 62'd0};

	localparam logic signed [POS_W-1:0] TARGET_RESET = 16'sd1200;
	localparam logic [GAIN_W-1:0] GAIN_P_RESET = 24'd65536;
	localparam logic [GAIN_W-1:0] GAIN_D_RESET = 24'd1638;
	localparam logic [GAIN_W-1:0] GAIN_I_RESET = 24'd0;

	localparam logic [1:0] REG_TARGET = 2'd0;
	localparam logic [1:0] REG_GAIN_P = 2'd1;
	localparam logic [1:0] REG_GAIN_D = 2'd2;
	localparam logic [1:0] REG_GAIN_I = 2'd3;

	localparam logic OP_EDGE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE, ST_ERR, ST_MINT, ST_MP, ST_MD1, ST_MD2, ST_DD, ST_MI, ST_DI, ST_SUM, ST_OUT
	} state_t;

	typedef struct packed {
		logic                start;
		logic [ITER_W-1:0]   iters;
		logic [PROD_W-1:0]   dividend;
		logic [TIME_W-1:0]   divisor;
	} div_req_t;

	typedef struct packed {
		logic [POS_W-1:0]   position;
		logic [LEVEL_W-1:0] right_pwm;
		logic [LEVEL_W-1:0] left_pwm;
		logic               bridge_enable;
	} res_t;

	typedef struct packed {
		logic signed [POS_W-1:0] target_position;
		logic [GAIN_W-1:0]       gain_p;
		logic [GAIN_W-1:0]       gain_d;
		logic [GAIN_W-1:0]       gain_i;
	} cfg_t;

endpackage

// ===== rtl/encoder_position_pid_drive.sv =====
// Channel  Dir  Bits  Contents
// s_axis   in   32    tdata: encoder_b[0], elapsed_us[24:1]; tuser: op
// m_axis   out  40    tdata: position[15:0], right_pwm[23:16], left_pwm[31:24], enable[32]
// cfg      in   24    write enable, 2-bit register index, data
// An encoder edge goes from the idle state straight to the output state. A control tick runs
// five multiplier passes and two divider passes (the first divider pass is skipped with zero
// elapsed time) before its result is loaded.
// Reset clears position, error history, integral and drive; registers take their defaults.
// A finished item waits in the output register while the next item is taken; while that
// register is full, the next finished item holds the core and the input stalls.
// Top level: configuration registers, output register. Depends on epd_pkg, epd_core.
module encoder_position_pid_drive (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // encoder_b, elapsed_us
	input  logic        s_axis_tuser,   // op
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,   // position, right_pwm, left_pwm, bridge_enable
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic [23:0] cfg_wdata
);
	import epd_pkg::*;

	cfg_t        cfg_q;
	res_t        res;
	logic        out_load;
	logic        out_free;
	logic        m_valid_q;
	logic [39:0] m_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target_position <= TARGET_RESET;
			cfg_q.gain_p          <= GAIN_P_RESET;
			cfg_q.gain_d          <= GAIN_D_RESET;
			cfg_q.gain_i          <= GAIN_I_RESET;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_TARGET: cfg_q.target_position <= cfg_wdata[POS_W-1:0];
				REG_GAIN_P: cfg_q.gain_p <= cfg_wdata;
				REG_GAIN_D: cfg_q.gain_d <= cfg_wdata;
				REG_GAIN_I: cfg_q.gain_i <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign out_free = !m_valid_q || m_axis_tready;

	epd_core u_core (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q),
		.in_valid(s_axis_tvalid), .in_op(s_axis_tuser), .in_b(s_axis_tdata[0]),
		.in_elapsed(s_axis_tdata[24:1]), .in_ready(s_axis_tready),
		.out_free(out_free), .out_load(out_load), .res(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_valid_q <= 1'b0;
		else if (out_load)
			m_valid_q <= 1'b1;
		else if (m_axis_tready)
			m_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load)
			m_data_q <= {7'd0, res.bridge_enable, res.left_pwm, res.right_pwm, res.position};
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

endmodule

// ===== rtl/epd_mul.sv =====
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// Depends on epd_pkg.
module epd_mul (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [epd_pkg::ACC_W-1:0]      a,
	input  logic [epd_pkg::GAIN_W-1:0]     b,
	output logic [epd_pkg::PROD_W-1:0]     prod,
	output logic                           done
);
	import epd_pkg::*;

	logic [PROD_W-1:0] mcand_q;
	logic [GAIN_W-1:0] mplier_q;
	logic [PROD_W-1:0] prod_q;
	logic [4:0]        cnt_q;
	logic              busy_q;
	logic              done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == 5'd1);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'(MUL_STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1)
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mcand_q  <= {24'd0, a};
			mplier_q <= b;
			prod_q   <= '0;
		end else if (busy_q) begin
			if (mplier_q[0])
				prod_q <= prod_q + mcand_q;
			mcand_q  <= {mcand_q[PROD_W-2:0], 1'b0};
			mplier_q <= {1'b0, mplier_q[GAIN_W-1:1]};
		end
	end

	assign prod = prod_q;
	assign done = done_q;

endmodule

// ===== rtl/epd_div.sv =====
// Restoring divider, one quotient bit per cycle, dividend aligned to the top.
// Depends on epd_pkg.
module epd_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  epd_pkg::div_req_t           req,
	output logic [epd_pkg::PROD_W-1:0]  quo,
	output logic                        done
);
	import epd_pkg::*;

	logic [PROD_W-1:0] dq_q;
	logic [TIME_W-1:0] rem_q;
	logic [TIME_W-1:0] dvs_q;
	logic [ITER_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [TIME_W:0]   r_sh;
	logic              ge;
	logic [TIME_W:0]   r_sub;

	assign r_sh  = {rem_q, dq_q[PROD_W-1]};
	assign ge    = r_sh >= {1'b0, dvs_q};
	assign r_sub = r_sh - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == 7'd1);
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.iters;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1)
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dq_q  <= req.dividend;
			dvs_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? r_sub[TIME_W-1:0] : r_sh[TIME_W-1:0];
			dq_q  <= {dq_q[PROD_W-2:0], ge};
		end
	end

	assign quo  = dq_q;
	assign done = done_q;

endmodule

// ===== rtl/epd_core.sv =====
// Sequencer and datapath: encoder count, PID terms, drive level.
// Depends on epd_pkg, epd_mul and epd_div.
module epd_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  epd_pkg::cfg_t               cfg,
	input  logic                        in_valid,
	input  logic                        in_op,
	input  logic                        in_b,
	input  logic [epd_pkg::TIME_W-1:0]  in_elapsed,
	output logic                        in_ready,
	input  logic                        out_free,
	output logic                        out_load,
	output epd_pkg::res_t               res
);
	import epd_pkg::*;

	state_t state_q, state_n;

	logic [POS_W-1:0]         count_q;
	logic signed [ERR_W-1:0]  prev_err_q;
	logic signed [ACC_W-1:0]  integ_q;
	logic [LEVEL_W-1:0]       level_q;
	logic                     rev_q;
	logic [TIME_W-1:0]        elapsed_q;
	logic signed [ERR_W-1:0]  err_q;
	logic signed [DIFF_W-1:0] diff_q;
	logic signed [41:0]       p_q;
	logic [61:0]              d_q;
	logic [62:0]              i_q;
	logic signed [SUM_W-1:0]  pd_q;

	logic                mul_start, mul_done;
	logic [ACC_W-1:0]    mul_a;
	logic [GAIN_W-1:0]   mul_b;
	logic [PROD_W-1:0]   mul_prod;
	div_req_t            div_req;
	logic [PROD_W-1:0]   div_quo;
	logic                div_done;

	logic signed [ERR_W-1:0]  err_c;
	logic [ERR_W-1:0]         err_c_abs, err_abs;
	logic [DIFF_W-1:0]        diff_abs;
	logic [ACC_W-1:0]         integ_abs;
	logic [41:0]              m42, s42;
	logic signed [ACC_W:0]    isum;
	logic signed [SUM_W-1:0]  p66, d66, i66, u;
	logic [SUM_W-1:0]         umag;
	logic [49:0]              ush;
	logic                     accept;

	epd_mul u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start), .a(mul_a), .b(mul_b),
		.prod(mul_prod), .done(mul_done)
	);

	epd_div u_div (
		.clk(clk), .arst_n(arst_n), .req(div_req), .quo(div_quo), .done(div_done)
	);

	assign accept    = in_valid && in_ready;
	assign err_c     = $signed({count_q[POS_W-1], count_q})
	                 - $signed({cfg.target_position[POS_W-1], cfg.target_position});
	assign err_c_abs = err_c[ERR_W-1] ? 17'(-err_c) : err_c;
	assign err_abs   = err_q[ERR_W-1] ? 17'(-err_q) : err_q;
	assign diff_abs  = diff_q[DIFF_W-1] ? 18'(-diff_q) : diff_q;
	assign integ_abs = integ_q[ACC_W-1] ? 64'(-integ_q) : integ_q;

	assign m42  = {1'b0, mul_prod[40:0]};
	assign s42  = err_q[ERR_W-1] ? 42'(-m42) : m42;
	assign isum = $signed({integ_q[ACC_W-1], integ_q}) + $signed({{23{s42[41]}}, s42});

	assign p66  = {{24{p_q[41]}}, p_q};
	assign d66  = diff_q[DIFF_W-1] ? 66'(-{4'd0, d_q}) : {4'd0, d_q};
	assign i66  = integ_q[ACC_W-1] ? 66'(-{3'd0, i_q}) : {3'd0, i_q};
	assign u    = pd_q + i66;
	assign umag = u[SUM_W-1] ? 66'(-u) : u;
	assign ush  = umag[SUM_W-1:16];

	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_IDLE: if (accept) state_n = (in_op == OP_TICK) ? ST_ERR : ST_OUT;
			ST_ERR:  state_n = ST_MINT;
			ST_MINT: if (mul_done) state_n = ST_MP;
			ST_MP:   if (mul_done) state_n = ST_MD1;
			ST_MD1:  if (mul_done) state_n = ST_MD2;
			ST_MD2:  if (mul_done) state_n = (elapsed_q == '0) ? ST_MI : ST_DD;
			ST_DD:   if (div_done) state_n = ST_MI;
			ST_MI:   if (mul_done) state_n = ST_DI;
			ST_DI:   if (div_done) state_n = ST_SUM;
			ST_SUM:  state_n = ST_OUT;
			ST_OUT:  if (out_free) state_n = ST_IDLE;
			default: state_n = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready         = 1'b0;
		out_load         = 1'b0;
		mul_start        = 1'b0;
		mul_a            = '0;
		mul_b            = '0;
		div_req.start    = 1'b0;
		div_req.iters    = DIV_I_ITERS;
		div_req.dividend = mul_prod;
		div_req.divisor  = US_PER_S;
		case (state_q)
			ST_IDLE: in_ready = 1'b1;
			ST_ERR: begin
				mul_start = 1'b1;
				mul_a     = {47'd0, err_c_abs};
				mul_b     = elapsed_q;
			end
			ST_MINT: begin
				mul_start = mul_done;
				mul_a     = {40'd0, cfg.gain_p};
				mul_b     = {7'd0, err_abs};
			end
			ST_MP: begin
				mul_start = mul_done;
				mul_a     = {40'd0, cfg.gain_d};
				mul_b     = {6'd0, diff_abs};
			end
			ST_MD1: begin
				mul_start = mul_done;
				mul_a     = mul_prod[ACC_W-1:0];
				mul_b     = US_PER_S;
			end
			ST_MD2: begin
				mul_start        = mul_done && (elapsed_q == '0);
				mul_a            = integ_abs;
				mul_b            = cfg.gain_i;
				div_req.start    = mul_done && (elapsed_q != '0);
				div_req.iters    = DIV_D_ITERS;
				div_req.dividend = {mul_prod[ACC_W-1:0], 24'd0};
				div_req.divisor  = elapsed_q;
			end
			ST_DD: begin
				mul_start = div_done;
				mul_a     = integ_abs;
				mul_b     = cfg.gain_i;
			end
			ST_MI: div_req.start = mul_done;
			ST_OUT: out_load = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			prev_err_q <= '0;
			integ_q    <= '0;
			level_q    <= '0;
			rev_q      <= 1'b0;
		end else begin
			state_q <= state_n;
			if (accept && in_op == OP_EDGE)
				count_q <= in_b ? count_q + 16'd1 : count_q - 16'd1;
			if (state_q == ST_MINT && mul_done) begin
				if (isum[ACC_W] != isum[ACC_W-1])
					integ_q <= isum[ACC_W] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
				else
					integ_q <= isum[ACC_W-1:0];
			end
			if (state_q == ST_SUM) begin
				rev_q      <= u[SUM_W-1];
				level_q    <= (ush > LEVEL_MAX) ? LEVEL_MAX[LEVEL_W-1:0] : ush[LEVEL_W-1:0];
				prev_err_q <= err_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			elapsed_q <= in_elapsed;
		if (state_q == ST_ERR) begin
			err_q  <= err_c;
			diff_q <= $signed({err_c[ERR_W-1], err_c}) - $signed({prev_err_q[ERR_W-1], prev_err_q});
		end
		if (state_q == ST_MP && mul_done)
			p_q <= $signed(err_q[ERR_W-1] ? 42'(-m42) : m42);
		if (state_q == ST_MD2 && mul_done && elapsed_q == '0)
			d_q <= '0;
		if (state_q == ST_DD && div_done)
			d_q <= div_quo[61:0];
		if (state_q == ST_DI && div_done) begin
			i_q  <= (div_quo > I_LIMIT) ? I_LIMIT[62:0] : div_quo[62:0];
			pd_q <= p66 + d66;
		end
	end

	always_comb begin
		res.position      = count_q;
		res.bridge_enable = (level_q != '0);
		res.right_pwm     = rev_q ? '0 : level_q;
		res.left_pwm      = rev_q ? level_q : '0;
	end

endmodule

// ===== rtl/epd_chk.sv =====
// Port-level checks for the encoder position PID drive, bound to the top level.
// Depends on the top level's ports only.
module epd_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [39:0] m_axis_tdata
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output item changed while stalled");

	a_enable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[32] ==
			((m_axis_tdata[23:16] != 8'd0) || (m_axis_tdata[31:24] != 8'd0))))
		else $error("bridge enable disagrees with duty");

	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !((m_axis_tdata[23:16] != 8'd0) && (m_axis_tdata[31:24] != 8'd0)))
		else $error("both bridge halves driven");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken while an item is in work");

endmodule

bind encoder_position_pid_drive epd_chk u_epd_chk (
	.clk(clk), .arst_n(arst_n),
	.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata)
);
